### src/ffsa_pkg.sv
// Package: widths, segment entry type, status and command codes, sequencer states and merge-unit controls.
`default_nettype none
package ffsa_pkg;
  localparam int MAX_SEG  = 64;
  localparam int HEAP_MAX = 65536;
  localparam int IDX_W    = $clog2(MAX_SEG);
  localparam int CNT_W    = $clog2(MAX_SEG + 1);
  localparam int LEN_W    = $clog2(HEAP_MAX + 1);

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             used;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EX,
    S_COPY_RD,
    S_COPY_EX,
    S_SPLIT,
    S_FLUSH,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic flush;
  } tidy_ctl_t;
endpackage
`default_nettype wire

### src/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/ffsa_tidy.sv
// Merge unit: drops empty free segments and coalesces adjacent free ones while streaming.
`default_nettype none
module ffsa_tidy (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffsa_pkg::tidy_ctl_t  ctl,
  input  wire ffsa_pkg::seg_t       item,
  output logic                      wr_en,
  output logic [ffsa_pkg::IDX_W-1:0] wr_addr,
  output ffsa_pkg::seg_t            wr_data,
  output logic [ffsa_pkg::CNT_W-1:0] wr_count
);
  import ffsa_pkg::*;

  seg_t             pend;
  logic             pend_valid;
  logic [CNT_W-1:0] wcnt;
  logic             drop;
  logic             merge;

  always_comb begin
    drop    = !item.used && (item.len == '0);
    merge   = !item.used && pend_valid && !pend.used;
    wr_en   = (ctl.push && !drop && !merge && pend_valid) || (ctl.flush && pend_valid);
    wr_addr = wcnt[IDX_W-1:0];
    wr_data = pend;
    wr_count = wcnt;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      pend_valid <= 1'b0;
      wcnt       <= '0;
    end else if (ctl.push) begin
      if (drop) begin
      end else if (merge) begin
        pend.len <= pend.len + item.len;
      end else begin
        pend       <= item;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          wcnt <= wcnt + 1'b1;
        end
      end
    end else if (ctl.flush && pend_valid) begin
      wcnt       <= wcnt + 1'b1;
      pend_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### src/first_fit_segment_allocator_top.sv
// Top level: first-fit segment allocator with sequencer, ping-pong segment table and merge unit.
//
//  channel | signals                                      | handshake
//  --------+----------------------------------------------+--------------------------
//  command | start, cmd, request_size, block_offset, busy | taken when start & !busy
//  result  | done, status, alloc_offset                   | one-cycle beat on done
//  config  | cfg_valid, cfg_ready, cfg_data (heap_bytes)  | taken when valid & ready
//
// A command scans the table up to the hit, reading and then comparing each entry, then copies
// all live entries through the merge unit into the other bank, reading and then pushing each
// entry (plus a split push at the hit), flushes and swaps banks; errors end after the scan,
// a zero-size allocation at once.
// Reset and a heap_bytes write each rewrite entry 0 in the init state.
// cfg_ready is low while start is high, so a command beat always wins.
// The result beat cannot be stalled; busy stays high until it has gone.
`default_nettype none
module first_fit_segment_allocator_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      cmd,
  input  wire logic [16:0]               request_size,
  input  wire logic [15:0]               block_offset,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [15:0]                    alloc_offset,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [16:0]               cfg_data
);
  import ffsa_pkg::*;

  state_t           state, state_next;
  logic             bank;
  logic [CNT_W-1:0] seg_count;
  logic [LEN_W-1:0] heap_bytes;
  logic             cmd_r;
  logic [LEN_W-1:0] size_r;
  logic [15:0]      offs_r;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] hit;
  seg_t             hit_seg;
  logic [2:0]       status_r;
  logic [15:0]      offset_r;

  seg_t             rd0, rd1, rdata, init_seg, item;
  tidy_ctl_t        tctl;
  logic             t_we;
  logic [IDX_W-1:0] t_addr;
  seg_t             t_data;
  logic [CNT_W-1:0] t_count;
  logic             we0, we1;
  logic [IDX_W-1:0] waddr;
  seg_t             wdata;
  logic             cfg_fire, start_fire, at_end, match, exact, is_hit;
  logic [LEN_W-1:0] cfg_clamped;

  assign rdata    = bank ? rd1 : rd0;
  assign init_seg = '{start: '0, len: heap_bytes, used: 1'b0};
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign start_fire = start && !busy;
  assign at_end   = (idx == seg_count);
  assign exact    = (hit_seg.len == size_r);
  assign is_hit   = (idx[IDX_W-1:0] == hit);
  assign match    = (cmd_r == CMD_ALLOC) ? (!rdata.used && rdata.len >= size_r)
                                         : (rdata.start == {1'b0, offs_r});

  always_comb begin
    cfg_clamped = cfg_data[LEN_W-1:0];
    if (cfg_data == '0) begin
      cfg_clamped = LEN_W'(1);
    end else if (cfg_data > LEN_W'(HEAP_MAX)) begin
      cfg_clamped = LEN_W'(HEAP_MAX);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (cfg_fire) begin
          state_next = S_INIT;
        end else if (start_fire) begin
          if (cmd == CMD_ALLOC && request_size == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_next = at_end ? S_DONE : S_SCAN_EX;
      S_SCAN_EX: begin
        if (!match) begin
          state_next = S_SCAN_RD;
        end else if (cmd_r == CMD_ALLOC && rdata.len != size_r && seg_count == CNT_W'(MAX_SEG)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_COPY_RD: state_next = at_end ? S_FLUSH : S_COPY_EX;
      S_COPY_EX: begin
        if (is_hit && cmd_r == CMD_ALLOC && !exact) begin
          state_next = S_SPLIT;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_SPLIT:  state_next = S_COPY_RD;
      S_FLUSH:  state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    cfg_ready = (state == S_IDLE) && !start;
    done      = (state == S_DONE);
    status    = status_r;
    alloc_offset = offset_r;
    tctl      = '{clr: 1'b0, push: 1'b0, flush: 1'b0};
    item      = rdata;
    unique case (state)
      S_SCAN_EX: tctl.clr = 1'b1;
      S_COPY_EX: begin
        tctl.push = 1'b1;
        if (is_hit) begin
          if (cmd_r == CMD_FREE) begin
            item.used = 1'b0;
          end else if (exact) begin
            item.used = 1'b1;
          end else begin
            item = '{start: rdata.start, len: size_r, used: 1'b1};
          end
        end
      end
      S_SPLIT: begin
        tctl.push = 1'b1;
        item = '{start: hit_seg.start + size_r, len: hit_seg.len - size_r, used: 1'b0};
      end
      S_FLUSH: tctl.flush = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state == S_INIT) begin
      we0   = !bank;
      we1   = bank;
      waddr = '0;
      wdata = init_seg;
    end else begin
      we0   = t_we && bank;
      we1   = t_we && !bank;
      waddr = t_addr;
      wdata = t_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      bank       <= 1'b0;
      seg_count  <= CNT_W'(1);
      heap_bytes <= LEN_W'(HEAP_MAX);
      status_r   <= ST_OK;
      offset_r   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT: seg_count <= CNT_W'(1);
        S_IDLE: begin
          if (cfg_fire) begin
            heap_bytes <= cfg_clamped;
          end else if (start_fire) begin
            cmd_r    <= cmd;
            size_r   <= request_size;
            offs_r   <= block_offset;
            idx      <= '0;
            status_r <= ST_ZERO;
            offset_r <= '0;
          end
        end
        S_SCAN_RD: begin
          if (at_end) begin
            status_r <= (cmd_r == CMD_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
          end
        end
        S_SCAN_EX: begin
          if (!match) begin
            idx <= idx + 1'b1;
          end else if (cmd_r == CMD_ALLOC && rdata.len != size_r
                       && seg_count == CNT_W'(MAX_SEG)) begin
            status_r <= ST_FULL;
          end else begin
            hit      <= idx[IDX_W-1:0];
            hit_seg  <= rdata;
            idx      <= '0;
            status_r <= ST_OK;
            offset_r <= (cmd_r == CMD_ALLOC) ? rdata.start[15:0] : '0;
          end
        end
        S_COPY_EX: begin
          if (!(is_hit && cmd_r == CMD_ALLOC && !exact)) begin
            idx <= idx + 1'b1;
          end
        end
        S_SPLIT: idx <= idx + 1'b1;
        S_COMMIT: begin
          bank      <= !bank;
          seg_count <= t_count;
        end
        default: begin
        end
      endcase
    end
  end

  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEG)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .raddr(idx[IDX_W-1:0]), .rdata(rd0)
  );

  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEG)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .raddr(idx[IDX_W-1:0]), .rdata(rd1)
  );

  ffsa_tidy u_tidy (
    .clk(clk), .rst(rst), .ctl(tctl), .item(item),
    .wr_en(t_we), .wr_addr(t_addr), .wr_data(t_data), .wr_count(t_count)
  );
endmodule
`default_nettype wire
